>>> sv/zero_residue_subarray_finder_defines.svh
// Assertion macros for the zero residue subarray finder.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ZERO_RESIDUE_SUBARRAY_FINDER_DEFINES_SVH
`define ZERO_RESIDUE_SUBARRAY_FINDER_DEFINES_SVH

// Same-cycle implication.
`define ZRSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ZRSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/zrsf_pkg.sv
// Shared constants, types and the modulo digit step of the finder.
// No dependencies.
package zrsf_pkg;

  localparam int VALUE_W      = 20;
  localparam int DIV_W        = 13;
  localparam int MAX_RESIDUES = 4096;
  localparam int RES_W        = $clog2(MAX_RESIDUES);
  localparam int POS_W        = 16;
  localparam int MAX_ITEMS    = 65535;
  localparam int DIGIT_W      = 4;
  localparam int MOD_STAGES   = VALUE_W / DIGIT_W;
  localparam int RED_STEPS    = RES_W / DIGIT_W;
  localparam int RCNT_W       = $clog2(RED_STEPS);
  localparam int EPOCH_W      = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [RES_W-1:0] vmod;
    logic             last;
  } qitem_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_REDUCE,
    BK_LOOKUP
  } back_state_t;

  function automatic logic [DIV_W-1:0] eff_divisor(input logic [DIV_W-1:0] d);
    logic [DIV_W-1:0] r;
    r = d;
    if (d == '0) r = DIV_W'(1);
    else if (d > DIV_W'(MAX_RESIDUES)) r = DIV_W'(MAX_RESIDUES);
    return r;
  endfunction

  // Shift one digit into a remainder below d, reducing after each bit.
  function automatic logic [RES_W-1:0] mod_step(input logic [RES_W-1:0]   rem,
                                                input logic [DIGIT_W-1:0] digit,
                                                input logic [DIV_W-1:0]   d);
    logic [RES_W-1:0] r;
    logic [DIV_W-1:0] t;
    r = rem;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      t = {r, digit[i]};
      if (t >= d) t = t - d;
      r = t[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/zero_residue_subarray_finder.sv
// Zero residue subarray finder: front modulo pipeline, request queue, table back end.
// The back end finishes each item before it pops the next, paced by its table read-modify-write
// (the idle state forms the residue and reads the first-position table, the lookup state updates
// it and forms the result); a stalled output holds it. The 5-stage value modulo pipeline adds
// latency ahead of the queue. After a divisor change inside a set, the next item waits while the
// held residue is reduced. A clearing pass over all 4096 table entries runs after reset and after
// every 255th set, and input is stalled while it runs. Divisor writes are taken at any time with
// cfg_ready high but must only happen when the block is idle.
// Depends on zrsf_pkg, zrsf_front, zrsf_queue, zrsf_back and the defines header.
`include "zero_residue_subarray_finder_defines.svh"

module zero_residue_subarray_finder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [zrsf_pkg::VALUE_W-1:0] in_value,
  input  logic                         in_last_in_set,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_found,
  output logic [zrsf_pkg::POS_W-1:0]   out_run_start,
  output logic [zrsf_pkg::POS_W-1:0]   out_run_end,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [zrsf_pkg::DIV_W-1:0]   cfg_divisor
);
  import zrsf_pkg::*;

  logic [DIV_W-1:0] div_r, div_nxt, div_eff;
  logic             front_blocked, clearing, take;
  logic             q_push, q_full, q_pop, q_valid;
  qitem_t           push_item, pop_item;

  assign cfg_ready = 1'b1;
  assign div_nxt   = (cfg_valid && cfg_ready) ? cfg_divisor : div_r;
  assign div_eff   = eff_divisor(div_r);
  assign in_stall  = front_blocked || clearing;
  assign take      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= DIV_W'(1);
    end else begin
      div_r <= div_nxt;
    end
  end

  zrsf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .div_eff     (div_eff),
    .take        (take),
    .value       (in_value),
    .last_in_set (in_last_in_set),
    .q_full      (q_full),
    .blocked     (front_blocked),
    .q_push      (q_push),
    .q_item      (push_item)
  );

  zrsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  zrsf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .div_eff       (div_eff),
    .q_valid       (q_valid),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_run_start (out_run_start),
    .out_run_end   (out_run_end)
  );

  `ZRSF_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid, "request popped from empty queue")
  `ZRSF_ASSERT_NOW(a_miss_zero, out_valid && !out_found, (out_run_start == '0) && (out_run_end == '0), "not-found result with nonzero range")
  `ZRSF_ASSERT_NOW(a_hit_range, out_valid && out_found, (out_run_start != '0) && (out_run_start <= out_run_end), "found result with bad range")

endmodule

>>> sv/zrsf_front.sv
// Front end: pipelined value modulo divisor, one digit per stage.
// Depends on zrsf_pkg; feeds zrsf_queue.
module zrsf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [zrsf_pkg::DIV_W-1:0]  div_eff,
  input  logic                        take,
  input  logic [zrsf_pkg::VALUE_W-1:0] value,
  input  logic                        last_in_set,
  input  logic                        q_full,
  output logic                        blocked,
  output logic                        q_push,
  output zrsf_pkg::qitem_t            q_item
);
  import zrsf_pkg::*;

  localparam int L = MOD_STAGES - 1;

  logic [MOD_STAGES-1:0] vld_r, vld_nxt;
  logic [RES_W-1:0]      rem_r  [MOD_STAGES];
  logic [RES_W-1:0]      rem_nxt[MOD_STAGES];
  logic [VALUE_W-1:0]    bits_r  [MOD_STAGES];
  logic [VALUE_W-1:0]    bits_nxt[MOD_STAGES];
  logic [MOD_STAGES-1:0] last_r, last_nxt;
  logic                  adv;

  assign adv     = !vld_r[L] || !q_full;
  assign blocked = !adv;
  assign q_push  = vld_r[L] && !q_full;
  assign q_item  = '{vmod: rem_r[L], last: last_r[L]};

  always_comb begin
    vld_nxt     = {vld_r[MOD_STAGES-2:0], take};
    rem_nxt[0]  = mod_step('0, value[VALUE_W-1 -: DIGIT_W], div_eff);
    bits_nxt[0] = {value[VALUE_W-DIGIT_W-1:0], DIGIT_W'(0)};
    last_nxt[0] = last_in_set;
    for (int i = 1; i < MOD_STAGES; i++) begin
      rem_nxt[i]  = mod_step(rem_r[i-1], bits_r[i-1][VALUE_W-1 -: DIGIT_W], div_eff);
      bits_nxt[i] = {bits_r[i-1][VALUE_W-DIGIT_W-1:0], DIGIT_W'(0)};
      last_nxt[i] = last_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      bits_r <= bits_nxt;
      last_r <= last_nxt;
    end
  end

endmodule

>>> sv/zrsf_queue.sv
// Short request queue between the front and back ends.
// Depends on zrsf_pkg.
module zrsf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  zrsf_pkg::qitem_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output zrsf_pkg::qitem_t pop_item
);
  import zrsf_pkg::*;

  qitem_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full     = cnt_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid    = cnt_r != '0;
  assign pop_item = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

endmodule

>>> sv/zrsf_back.sv
// Back end: running residue, first-position table with epoch tags, result register.
// Depends on zrsf_pkg; drains zrsf_queue.
module zrsf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [zrsf_pkg::DIV_W-1:0] div_eff,
  input  logic                       q_valid,
  input  zrsf_pkg::qitem_t           q_item,
  output logic                       q_pop,
  output logic                       clearing,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_found,
  output logic [zrsf_pkg::POS_W-1:0] out_run_start,
  output logic [zrsf_pkg::POS_W-1:0] out_run_end
);
  import zrsf_pkg::*;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [POS_W-1:0]   fpos;
  } entry_t;

  entry_t mem [MAX_RESIDUES];
  entry_t mem_q, mem_wdata;
  logic   mem_we;
  logic [RES_W-1:0] mem_waddr, mem_raddr;

  back_state_t        state_r, state_nxt;
  logic [RES_W-1:0]   rr_r, rr_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               ans_r, ans_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [RES_W-1:0]   clr_r, clr_nxt;
  logic [RES_W-1:0]   res_r, res_nxt;
  logic               last_r, last_nxt;
  logic [RES_W-1:0]   red_rem_r, red_rem_nxt, red_bits_r, red_bits_nxt;
  logic [RCNT_W-1:0]  red_cnt_r, red_cnt_nxt;
  logic               oval_r, oval_nxt;
  logic               ofound_r, ofound_nxt;
  logic [POS_W-1:0]   ostart_r, ostart_nxt, oend_r, oend_nxt;
  logic               out_load;

  logic               out_free, active, set_done, seen;
  logic [DIV_W-1:0]   sum;
  logic [RES_W-1:0]   res_calc;
  logic [POS_W-1:0]   pos_inc;

  assign out_free  = !oval_r || !out_stall;
  assign active    = !ans_r && (pos_r < POS_W'(MAX_ITEMS));
  assign sum       = {1'b0, rr_r} + {1'b0, q_item.vmod};
  assign res_calc  = (sum >= div_eff) ? RES_W'(sum - div_eff) : RES_W'(sum);
  assign mem_raddr = res_calc;
  assign pos_inc   = pos_r + 1'b1;
  assign seen      = mem_q.tag == epoch_r;
  assign clearing  = state_r == BK_CLEAR;

  assign out_valid     = oval_r;
  assign out_found     = ofound_r;
  assign out_run_start = ostart_r;
  assign out_run_end   = oend_r;

  always_comb begin
    state_nxt    = state_r;
    rr_nxt       = rr_r;
    pos_nxt      = pos_r;
    ans_nxt      = ans_r;
    epoch_nxt    = epoch_r;
    clr_nxt      = clr_r;
    res_nxt      = res_r;
    last_nxt     = last_r;
    red_rem_nxt  = red_rem_r;
    red_bits_nxt = red_bits_r;
    red_cnt_nxt  = red_cnt_r;
    oval_nxt     = oval_r && out_stall;
    out_load     = 1'b0;
    ofound_nxt   = 1'b0;
    ostart_nxt   = '0;
    oend_nxt     = '0;
    mem_we       = 1'b0;
    mem_waddr    = res_r;
    mem_wdata    = '{tag: epoch_r, fpos: pos_inc};
    q_pop        = 1'b0;
    set_done     = 1'b0;

    unique case (state_r)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == RES_W'(MAX_RESIDUES - 1)) begin
          state_nxt = BK_IDLE;
          epoch_nxt = EPOCH_W'(1);
        end
      end
      BK_IDLE: begin
        if ({1'b0, rr_r} >= div_eff) begin
          state_nxt    = BK_REDUCE;
          red_rem_nxt  = '0;
          red_bits_nxt = rr_r;
          red_cnt_nxt  = '0;
        end else if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (active) begin
            res_nxt   = res_calc;
            last_nxt  = q_item.last;
            state_nxt = BK_LOOKUP;
          end else if (q_item.last) begin
            if (!ans_r) begin
              out_load = 1'b1;
              oval_nxt = 1'b1;
            end
            set_done = 1'b1;
          end
        end
      end
      BK_REDUCE: begin
        red_rem_nxt  = mod_step(red_rem_r, red_bits_r[RES_W-1 -: DIGIT_W], div_eff);
        red_bits_nxt = {red_bits_r[RES_W-DIGIT_W-1:0], DIGIT_W'(0)};
        red_cnt_nxt  = red_cnt_r + 1'b1;
        if (red_cnt_r == RCNT_W'(RED_STEPS - 1)) begin
          rr_nxt    = red_rem_nxt;
          state_nxt = BK_IDLE;
        end
      end
      BK_LOOKUP: begin
        state_nxt = BK_IDLE;
        rr_nxt    = res_r;
        pos_nxt   = pos_inc;
        if (res_r == '0) begin
          out_load   = 1'b1;
          oval_nxt   = 1'b1;
          ofound_nxt = 1'b1;
          ostart_nxt = POS_W'(1);
          oend_nxt   = pos_inc;
          ans_nxt    = 1'b1;
        end else if (seen) begin
          out_load   = 1'b1;
          oval_nxt   = 1'b1;
          ofound_nxt = 1'b1;
          ostart_nxt = mem_q.fpos + 1'b1;
          oend_nxt   = pos_inc;
          ans_nxt    = 1'b1;
        end else begin
          mem_we = 1'b1;
          if (last_r) begin
            out_load = 1'b1;
            oval_nxt = 1'b1;
          end
        end
        if (last_r) set_done = 1'b1;
      end
      default: state_nxt = BK_IDLE;
    endcase

    if (set_done) begin
      rr_nxt  = '0;
      pos_nxt = '0;
      ans_nxt = 1'b0;
      if (epoch_r == {EPOCH_W{1'b1}}) begin
        state_nxt = BK_CLEAR;
        clr_nxt   = '0;
      end else begin
        epoch_nxt = epoch_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      clr_r   <= '0;
      epoch_r <= EPOCH_W'(1);
      rr_r    <= '0;
      pos_r   <= '0;
      ans_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      epoch_r <= epoch_nxt;
      rr_r    <= rr_nxt;
      pos_r   <= pos_nxt;
      ans_r   <= ans_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    last_r     <= last_nxt;
    red_rem_r  <= red_rem_nxt;
    red_bits_r <= red_bits_nxt;
    red_cnt_r  <= red_cnt_nxt;
    if (out_load) begin
      ofound_r <= ofound_nxt;
      ostart_r <= ostart_nxt;
      oend_r   <= oend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

endmodule
